// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions used across the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/larq_pkg.sv
// ---------------------------------------------------------------------------
// larq_pkg
// Types and constants for the line-assembling ring queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package larq_pkg;

    // Word field widths
    localparam int MODE_W = 2;
    localparam int DATA_W = 8;
    localparam int OFF_W  = 7;
    localparam int LEN_W  = 7;
    localparam int WAIT_W = 3;

    // Byte that closes a line
    localparam logic [DATA_W-1:0] NEWLINE_CODE = 8'd10;

    // Saturation limits of the reported fields
    localparam logic [LEN_W-1:0]  LEN_MAX  = 7'd127;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 3'd7;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH    = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_READ    = 2'd2
    } t_mode;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RESP = 1'b1
    } t_state;

endpackage

// File: hw/rtl/larq_item_if.sv
// ---------------------------------------------------------------------------
// larq_item_if
// Input channel: one operation word per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface larq_item_if
    import larq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] byte_in;
    logic [OFF_W-1:0]  read_offset;

    modport source (output valid, output mode, output byte_in, output read_offset,
                    input ready);
    modport sink   (input valid, input mode, input byte_in, input read_offset,
                    output ready);
endinterface

// File: hw/rtl/larq_result_if.sv
// ---------------------------------------------------------------------------
// larq_result_if
// Output channel: one status/result word per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface larq_result_if
    import larq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_byte;
    logic [LEN_W-1:0]  oldest_length;
    logic [WAIT_W-1:0] lines_waiting;
    logic              queue_empty;
    logic              overflow_seen;

    modport source (output valid, output read_byte, output oldest_length,
                    output lines_waiting, output queue_empty, output overflow_seen,
                    input ready);
    modport sink   (input valid, input read_byte, input oldest_length,
                    input lines_waiting, input queue_empty, input overflow_seen,
                    output ready);
endinterface

// File: hw/rtl/larq_ram.sv
// ---------------------------------------------------------------------------
// larq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module larq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/line_assembling_ring_queue.sv
// Line-assembling ring queue. Bytes pushed into the block are gathered into
// line slots of a ring held in a single-port-per-direction line RAM; a newline
// closes the current line and records its length in a small length RAM. For
// each operation word, in the accept cycle the one line-RAM access (write of
// a pushed byte or read of a stored byte) and the length-RAM access are
// issued; in the response state the registered RAM data returns and, once
// the output register is empty or being drained, the result word is loaded
// into it. No new word is taken until that load; the output register lets
// a word be accepted while the previous result still waits. Neither RAM is
// cleared after reset, so the block is ready as soon as reset is released.
`timescale 1ns / 1ps

`include "assert_macros.svh"

// ---------------------------------------------------------------------------
// line_assembling_ring_queue
// Top level: pointer registers, sequencer, line/length RAMs, output register.
// ---------------------------------------------------------------------------
module line_assembling_ring_queue
    import larq_pkg::*;
#(
    parameter int LINE_SLOTS = 8,
    parameter int LINE_BYTES = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    larq_item_if.sink     i_item,
    larq_result_if.source o_result
);

    localparam int SLOT_W    = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int BYTE_W    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CNT_W     = $clog2(LINE_BYTES + 1);
    localparam int LINE_AW   = SLOT_W + BYTE_W;
    localparam int LINE_DEP  = LINE_SLOTS * (2 ** BYTE_W);

    // Pointer and flag registers
    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic [SLOT_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic                r_overflow, n_overflow;
    logic                r_rd_hit, n_rd_hit;
    logic                r_len_fwd, n_len_fwd;
    logic [LEN_W-1:0]    r_len_fwd_data;

    // Output register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_read_byte;
    logic [LEN_W-1:0]    r_oldest_length;
    logic [WAIT_W-1:0]   r_lines_waiting;
    logic                r_queue_empty;
    logic                r_overflow_seen;

    // RAM ports
    logic                line_we, line_re;
    logic [LINE_AW-1:0]  line_waddr, line_raddr;
    logic [DATA_W-1:0]   line_rdata;
    logic                len_we;
    logic [SLOT_W-1:0]   len_raddr;
    logic [LEN_W-1:0]    len_wdata, len_rdata;

    logic                acc;
    logic                load_out;
    logic [SLOT_W-1:0]   head_next, tail_next;
    logic [8:0]          off_ext;
    logic [8:0]          len_raw;
    logic [9:0]          wait_diff;
    logic                cur_empty;
    logic [LEN_W-1:0]    cur_length;
    logic [WAIT_W-1:0]   cur_waiting;

    // No word is taken while reset is held
    assign i_item.ready = i_rst_n && (r_state == ST_IDLE);
    assign acc          = i_item.valid && i_item.ready;

    // Ring successors
    assign head_next = (r_head == SLOT_W'(LINE_SLOTS - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == SLOT_W'(LINE_SLOTS - 1)) ? '0 : r_tail + 1'b1;

    // Closed-line length: count minus one, saturated to the field
    assign len_raw   = (r_fill == '0) ? 9'd0 : 9'(r_fill) - 9'd1;
    assign len_wdata = (len_raw > 9'(LEN_MAX)) ? LEN_MAX : len_raw[LEN_W-1:0];
    assign off_ext   = 9'(i_item.read_offset);

    // Operation decode and RAM command generation
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_overflow = r_overflow;
        n_rd_hit   = r_rd_hit;
        n_len_fwd  = r_len_fwd;
        line_we    = 1'b0;
        line_re    = 1'b0;
        line_waddr = {r_head, r_fill[BYTE_W-1:0]};
        line_raddr = {r_tail, off_ext[BYTE_W-1:0]};
        len_we     = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_state  = ST_RESP;
                    n_rd_hit = 1'b0;
                    unique case (t_mode'(i_item.mode))
                        MODE_PUSH: begin
                            if (i_item.byte_in != NEWLINE_CODE) begin
                                if (r_fill < CNT_W'(LINE_BYTES)) begin
                                    line_we = 1'b1;
                                    n_fill  = r_fill + 1'b1;
                                end
                            end else if (head_next != r_tail) begin
                                len_we = 1'b1;
                                n_fill = '0;
                                n_head = head_next;
                            end else begin
                                n_overflow = 1'b1;
                            end
                        end
                        MODE_RELEASE: begin
                            if (r_head != r_tail) begin
                                n_tail = tail_next;
                            end
                        end
                        MODE_READ: begin
                            if ((r_head != r_tail) && (off_ext < 9'(LINE_BYTES))) begin
                                line_re  = 1'b1;
                                n_rd_hit = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // Length read of the new tail overlaps a write to it
                    n_len_fwd = len_we && (r_head == n_tail);
                end
            end
            ST_RESP: begin
                if (!r_out_valid || o_result.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign len_raddr = n_tail;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_overflow <= 1'b0;
            r_rd_hit   <= 1'b0;
            r_len_fwd  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_overflow <= n_overflow;
            r_rd_hit   <= n_rd_hit;
            r_len_fwd  <= n_len_fwd;
        end
    end

    // Forwarded length word
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_fwd_data <= len_wdata;
        end
    end

    // Line storage
    larq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_DEP),
        .AW    (LINE_AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_waddr),
        .i_wdata (i_item.byte_in),
        .i_re    (line_re),
        .i_raddr (line_raddr),
        .o_rdata (line_rdata)
    );

    // Length storage, read at the tail after every operation
    larq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (LINE_SLOTS),
        .AW    (SLOT_W)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_head),
        .i_wdata (len_wdata),
        .i_re    (acc),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    // Status from the updated pointers
    assign cur_empty   = (r_head == r_tail);
    assign wait_diff   = (r_head >= r_tail)
                         ? 10'(r_head) - 10'(r_tail)
                         : 10'(r_head) + 10'(LINE_SLOTS) - 10'(r_tail);
    assign cur_waiting = (wait_diff > 10'(WAIT_MAX)) ? WAIT_MAX : wait_diff[WAIT_W-1:0];
    assign cur_length  = cur_empty ? '0 : (r_len_fwd ? r_len_fwd_data : len_rdata);

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_read_byte     <= r_rd_hit ? line_rdata : '0;
            r_oldest_length <= cur_length;
            r_lines_waiting <= cur_waiting;
            r_queue_empty   <= cur_empty;
            r_overflow_seen <= r_overflow;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.read_byte     = r_read_byte;
    assign o_result.oldest_length = r_oldest_length;
    assign o_result.lines_waiting = r_lines_waiting;
    assign o_result.queue_empty   = r_queue_empty;
    assign o_result.overflow_seen = r_overflow_seen;

    // Checks
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE) && !r_out_valid, "reset did not idle the block")
    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= CNT_W'(LINE_BYTES), "fill count past line capacity")
    `ASSERT_CLK(a_ptr_range, i_clk, i_rst_n, (r_head < SLOT_W'(LINE_SLOTS - 1)) || (r_head == SLOT_W'(LINE_SLOTS - 1)) || (r_tail == r_head), "head pointer outside ring")
    `ASSERT_CLK(a_overflow_sticky, i_clk, i_rst_n, r_overflow |=> r_overflow, "overflow flag cleared")
    `ASSERT_CLK(a_empty_vs_count, i_clk, i_rst_n, o_result.valid |-> (o_result.queue_empty == (o_result.lines_waiting == '0)), "empty flag disagrees with line count")

endmodule

// File: test/line_assembling_ring_queue_tb.sv
// ---------------------------------------------------------------------------
// line_assembling_ring_queue_tb
// Self-checking bench for the line-assembling ring queue. A directed table
// walks reset status, byte extremes, line close, ring-full overflow, release
// and read. Random line traffic follows, mixed with reads, releases and noise.
// Each result word is compared with a cycle-free model or a fixed table row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_assembling_ring_queue_tb;
    import larq_pkg::*;

    localparam int LINE_SLOTS   = 8;
    localparam int LINE_BYTES   = 128;
    localparam int SLOT_W       = $clog2(LINE_SLOTS);
    localparam int FILL_W       = $clog2(LINE_BYTES + 1);
    localparam int RANDOM_WORDS = 400;
    localparam int PHASE_WORDS  = 50;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RESET_CYCLES = 12;

    // Mode code with no operation behind it
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Idle percentages per phase: none, sender, receiver, both
    localparam int SEND_IDLE_PCT [4] = '{0, 69, 0, 23};
    localparam int RECV_IDLE_PCT [4] = '{0, 0, 69, 23};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] byte_in;
        logic [OFF_W-1:0]  read_offset;
    } t_op_word;

    typedef struct packed {
        logic [DATA_W-1:0] read_byte;
        logic [LEN_W-1:0]  oldest_length;
        logic [WAIT_W-1:0] lines_waiting;
        logic              queue_empty;
        logic              overflow_seen;
    } t_status_word;

    typedef struct packed {
        t_op_word     op;
        logic         fixed;
        t_status_word want;
    } t_dir_row;

    localparam t_status_word EMPTY_STATUS = '{8'h00, 7'd0, 3'd0, 1'b1, 1'b0};
    localparam int DIR_ROWS = 23;

    // Directed walk; rows with fixed set carry their status word inline
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{MODE_RELEASE, 8'h00, 7'd0},   1'b1, EMPTY_STATUS},
        '{'{MODE_READ,    8'hFF, 7'd127}, 1'b1, EMPTY_STATUS},
        '{'{MODE_SPARE,   8'h5A, 7'd0},   1'b1, EMPTY_STATUS},
        '{'{MODE_PUSH,    8'h00, 7'd0},   1'b0, '0},
        '{'{MODE_PUSH,    8'hFF, 7'd127}, 1'b0, '0},
        '{'{MODE_PUSH,    8'h80, 7'd0},   1'b0, '0},
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b0, '0},
        '{'{MODE_READ,    8'h00, 7'd0},   1'b0, '0},
        '{'{MODE_READ,    8'h00, 7'd1},   1'b0, '0},
        '{'{MODE_READ,    8'h00, 7'd2},   1'b0, '0},
        '{'{MODE_PUSH,    8'h7F, 7'd0},   1'b0, '0},
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b0, '0},
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b0, '0},
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b0, '0},
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b0, '0},
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b0, '0},
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b0, '0},
        // ring holds seven lines: this newline only raises overflow
        '{'{MODE_PUSH,    NEWLINE_CODE, 7'd0}, 1'b1, '{8'h00, 7'd2, WAIT_MAX, 1'b0, 1'b1}},
        '{'{MODE_PUSH,    8'h55, 7'd0},   1'b0, '0},
        '{'{MODE_RELEASE, 8'h00, 7'd0},   1'b0, '0},
        '{'{MODE_READ,    8'h00, 7'd0},   1'b0, '0},
        '{'{MODE_SPARE,   8'hA5, 7'd127}, 1'b0, '0},
        '{'{MODE_RELEASE, 8'h00, 7'd0},   1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    larq_item_if   item_ch ();
    larq_result_if result_ch ();

    line_assembling_ring_queue #(
        .LINE_SLOTS(LINE_SLOTS),
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Queue model state
    logic [DATA_W-1:0] q_lines   [LINE_SLOTS][LINE_BYTES];
    bit                q_written [LINE_SLOTS][LINE_BYTES];
    logic [LEN_W-1:0]  q_len     [LINE_SLOTS];
    logic [SLOT_W-1:0] q_head;
    logic [SLOT_W-1:0] q_tail;
    logic [FILL_W-1:0] q_fill;
    logic              q_ovf;

    t_status_word status_due_q [$];
    int wrong_words;
    int live_words;
    int idle_cycles;
    int send_pct;
    int recv_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
        return (int'(s) == LINE_SLOTS - 1) ? '0 : s + 1'b1;
    endfunction

    // Applies one operation word to the model, returns the status word it causes
    function automatic t_status_word ring_queue_apply(input t_op_word op);
        t_status_word r;
        int len;
        int waiting;
        r = '0;
        case (op.mode)
            MODE_PUSH: begin
                if (op.byte_in != NEWLINE_CODE) begin
                    if (int'(q_fill) < LINE_BYTES) begin
                        q_lines[q_head][q_fill]   = op.byte_in;
                        q_written[q_head][q_fill] = 1'b1;
                        q_fill = q_fill + 1'b1;
                    end
                end else if (slot_after(q_head) != q_tail) begin
                    len = (q_fill == 0) ? 0 : int'(q_fill) - 1;
                    if (len > int'(LEN_MAX))
                        len = int'(LEN_MAX);
                    q_len[q_head] = LEN_W'(len);
                    q_fill = '0;
                    q_head = slot_after(q_head);
                end else begin
                    q_ovf = 1'b1;
                end
            end
            MODE_RELEASE: begin
                if (q_head != q_tail)
                    q_tail = slot_after(q_tail);
            end
            MODE_READ: begin
                if (q_head != q_tail && int'(op.read_offset) < LINE_BYTES)
                    r.read_byte = q_lines[q_tail][op.read_offset];
            end
            default: ;
        endcase
        waiting = (q_head >= q_tail) ? int'(q_head) - int'(q_tail)
                                     : int'(q_head) + LINE_SLOTS - int'(q_tail);
        if (waiting > int'(WAIT_MAX))
            waiting = int'(WAIT_MAX);
        r.queue_empty   = (q_head == q_tail);
        r.oldest_length = r.queue_empty ? '0 : q_len[q_tail];
        r.lines_waiting = WAIT_W'(waiting);
        r.overflow_seen = q_ovf;
        return r;
    endfunction

    // Drives one word, waits for its acceptance, then books the expected status
    task automatic send_word(input t_op_word op, input logic fixed,
                             input t_status_word want);
        t_status_word due;
        int start;
        int idx;
        bit found;
        bit was_empty;
        found = 1'b0;
        if (send_pct > 0 && $urandom_range(99) < send_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_pct);
        end
        // never read a byte of the oldest slot that was not written yet
        if (op.mode == MODE_READ && q_head != q_tail
                && !q_written[q_tail][op.read_offset]) begin
            start = $urandom_range(LINE_BYTES - 1);
            for (int k = 0; k < LINE_BYTES; k++) begin
                idx = (start + k) % LINE_BYTES;
                if (!found && q_written[q_tail][idx]) begin
                    op.read_offset = OFF_W'(idx);
                    found = 1'b1;
                end
            end
            if (!found)
                op.mode = MODE_SPARE;
        end
        item_ch.valid       <= 1'b1;
        item_ch.mode        <= op.mode;
        item_ch.byte_in     <= op.byte_in;
        item_ch.read_offset <= op.read_offset;
        do @(posedge i_clk); while (!item_ch.ready);
        was_empty = (q_head == q_tail);
        due = ring_queue_apply(op);
        status_due_q.push_back(fixed ? want : due);
        if (!(op.mode == MODE_SPARE || (op.mode == MODE_RELEASE && was_empty)))
            live_words++;
    endtask

    // Stimulus
    initial begin
        t_op_word w;
        int pick;
        int len;
        int n;
        int phase;
        bit fill_heavy;
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.mode        <= MODE_PUSH;
        item_ch.byte_in     <= '0;
        item_ch.read_offset <= '0;
        wrong_words = 0;
        live_words  = 0;
        send_pct    = 0;
        recv_pct    = 0;
        q_head = '0;
        q_tail = '0;
        q_fill = '0;
        q_ovf  = 1'b0;
        for (int s = 0; s < LINE_SLOTS; s++) begin
            q_len[s] = '0;
            for (int b = 0; b < LINE_BYTES; b++) begin
                q_lines[s][b]   = '0;
                q_written[s][b] = 1'b0;
            end
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_word(DIR_TABLE[i].op, DIR_TABLE[i].fixed, DIR_TABLE[i].want);

        // Random traffic: mostly whole lines, with reads, releases and noise
        live_words = 0;
        while (live_words < RANDOM_WORDS) begin
            phase      = (live_words / PHASE_WORDS) % 4;
            send_pct   = SEND_IDLE_PCT[phase];
            recv_pct   = RECV_IDLE_PCT[phase];
            fill_heavy = ((live_words / PHASE_WORDS) % 3) != 2;
            pick       = $urandom_range(99);
            w.read_offset = OFF_W'($urandom_range(127));
            if (pick < (fill_heavy ? 55 : 25)) begin
                n = $urandom_range(49);
                if (n == 0)
                    len = $urandom_range(135, 120);
                else if (n < 8)
                    len = $urandom_range(40, 9);
                else
                    len = $urandom_range(8);
                w.mode = MODE_PUSH;
                repeat (len) begin
                    w.byte_in = DATA_W'($urandom_range(255));
                    if (w.byte_in == NEWLINE_CODE)
                        w.byte_in = w.byte_in ^ 8'h01;
                    w.read_offset = OFF_W'($urandom_range(127));
                    send_word(w, 1'b0, '0);
                end
                w.byte_in = NEWLINE_CODE;
                send_word(w, 1'b0, '0);
            end else if (pick < (fill_heavy ? 80 : 55)) begin
                w.mode = MODE_READ;
                repeat ($urandom_range(4, 1)) begin
                    w.byte_in     = DATA_W'($urandom_range(255));
                    w.read_offset = OFF_W'(($urandom_range(3) == 0) ? $urandom_range(127)
                                                                    : $urandom_range(7));
                    send_word(w, 1'b0, '0);
                end
            end else if (pick < 95) begin
                w.mode = MODE_RELEASE;
                repeat ($urandom_range(2, 1)) begin
                    w.byte_in = DATA_W'($urandom_range(255));
                    send_word(w, 1'b0, '0);
                end
            end else begin
                w.mode    = MODE_W'($urandom_range(3));
                w.byte_in = DATA_W'($urandom_range(255));
                send_word(w, 1'b0, '0);
            end
        end
        item_ch.valid <= 1'b0;

        while (status_due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (wrong_words == 0 && status_due_q.size() == 0)
            $display("line_assembling_ring_queue: match");
        else
            $display("line_assembling_ring_queue: mismatch");
        $finish;
    end

    // Receiver: random stalls, result check, activity tracking
    initial begin
        t_status_word got;
        t_status_word want;
        result_ch.ready <= 1'b0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (result_ch.valid && result_ch.ready) begin
                got = '{result_ch.read_byte, result_ch.oldest_length,
                        result_ch.lines_waiting, result_ch.queue_empty,
                        result_ch.overflow_seen};
                if (status_due_q.size() == 0) begin
                    wrong_words++;
                    if (wrong_words <= MAX_REPORTS)
                        $display("ERROR: result word with none pending: %p", got);
                end else begin
                    want = status_due_q.pop_front();
                    if (got.read_byte !== want.read_byte
                            || got.oldest_length !== want.oldest_length
                            || got.lines_waiting !== want.lines_waiting
                            || got.queue_empty !== want.queue_empty
                            || got.overflow_seen !== want.overflow_seen) begin
                        wrong_words++;
                        if (wrong_words <= MAX_REPORTS)
                            $display({"ERROR: byte %h/%h len %0d/%0d wait %0d/%0d ",
                                      "empty %b/%b ovf %b/%b (exp/got)"},
                                     want.read_byte, got.read_byte,
                                     want.oldest_length, got.oldest_length,
                                     want.lines_waiting, got.lines_waiting,
                                     want.queue_empty, got.queue_empty,
                                     want.overflow_seen, got.overflow_seen);
                    end
                end
            end
            result_ch.ready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial begin
        @(posedge i_clk);
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("line_assembling_ring_queue: mismatch");
        $finish;
    end

endmodule
